[rtl/core/servo_pulse_mapper_smoother_macros.svh]
// Assertion macros for the servo pulse mapper and smoother.
// Included by the top level; no other dependencies.
`ifndef SERVO_PULSE_MAPPER_SMOOTHER_MACROS_SVH
`define SERVO_PULSE_MAPPER_SMOOTHER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define SPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sps_pkg.sv]
// Shared types and constants for the servo pulse mapper and smoother.
// No dependencies; imported by servo_pulse_mapper_smoother.
package sps_pkg;

   localparam int unsigned PULSE_W    = 16;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned WEIGHT_W   = 16;
   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // shift-add multiply and restoring divide both take this many steps
   localparam int unsigned STEPS = 16;
   localparam int unsigned CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(STEPS - 1);

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_MOVE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_INIT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERTED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT   = 3'd4;

   // register reset values
   localparam int unsigned RST_MIN_PULSE = 1000;
   localparam int unsigned RST_MAX_PULSE = 2000;
   localparam int unsigned RST_WEIGHT    = 58982;
   localparam int unsigned RST_DEFAULT   = 1500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } sps_state_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [POS_W-1:0]      position;
   } sps_req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] target_pulse_us;
      logic [PULSE_W-1:0] current_pulse_us;
      logic [POS_W-1:0]   logical_position;
      logic               status;
   } sps_rsp_type;

endpackage

[rtl/core/servo_pulse_mapper_smoother.sv]
// Servo position to pulse mapper with exponential pulse smoothing.
// Depends on sps_pkg and servo_pulse_mapper_smoother_macros.svh.
//
//   port group   dir   handshake            word
//   req_*        in    req_valid/req_stall  sps_req_type (req_type, position)
//   rsp_*        out   rsp_valid/rsp_stall  sps_rsp_type (pulses, position, status)
//   csr_*        in    csr_wr_en            csr_index, csr_wr_data
//
// One word at a time through a single 17-bit add/subtract unit.
// Move and init: accept, load, 16 multiply steps, 16 divide steps and
// finish; tick: accept, load, 16 multiply steps and finish; out-of-range
// move or unused code: accept, load and finish.
// A finished result waits in the output register; the next word is taken
// meanwhile, and the finish step holds while that register is stalled.
// Synchronous reset loads the pulse state as an init under reset registers.
`include "servo_pulse_mapper_smoother_macros.svh"

module servo_pulse_mapper_smoother #(
   parameter int unsigned POSITION_MAX = 999
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  sps_pkg::sps_req_type                 req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output sps_pkg::sps_rsp_type                 rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [sps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sps_pkg::CSR_DATA_W-1:0]       csr_wr_data
);
   import sps_pkg::*;

   localparam logic [POS_W-1:0] PM_W = POS_W'(POSITION_MAX);
   localparam int unsigned RST_STORED =
      ((RST_DEFAULT - RST_MIN_PULSE) * POSITION_MAX) / (RST_MAX_PULSE - RST_MIN_PULSE);

   // registers
   sps_state_type           state_ff, state_in;
   logic [PULSE_W-1:0]      min_ff, max_ff, def_ff;
   logic [WEIGHT_W-1:0]     weight_ff;
   logic                    inv_ff;
   logic [PULSE_W-1:0]      target_ff, target_in;
   logic [PULSE_W-1:0]      current_ff, current_in;
   logic [POS_W-1:0]        stored_ff, stored_in;
   sps_req_type             req_ff;
   logic [15:0]             hi_ff, hi_in;
   logic [15:0]             lo_ff, lo_in;
   logic [15:0]             opd_ff, opd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    neg_ff, neg_in;
   logic                    oor_ff, oor_in;
   logic [15:0]             arg_ff, arg_in;
   sps_rsp_type             rsp_ff;
   logic                    rsp_valid_ff;

   logic                    req_take;
   logic                    fin_go;

   // operand preparation
   logic                    span_neg;
   logic [PULSE_W-1:0]      span_mag;
   logic [PULSE_W-1:0]      bnd_lo, bnd_hi, dflt_clamp, dflt_off, dflt_pulse;
   logic [POS_W-1:0]        pos_eff;
   logic                    pos_oor;
   logic                    cur_ge;
   logic [PULSE_W-1:0]      tick_mag;

   // shared add/subtract unit
   logic [16:0]             alu_a, alu_b;
   logic                    alu_sub;
   logic [17:0]             alu_res;
   logic [16:0]             mul_sum;

   // finish values
   logic [PULSE_W-1:0]      move_pulse;
   logic [POS_W-1:0]        init_pos, init_stored;
   logic [33:0]             tick_base, tick_prod, tick_sum;
   logic [PULSE_W-1:0]      tick_pulse;
   logic [POS_W-1:0]        logical_in;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign fin_go    = (state_ff == ST_FIN) && !(rsp_valid_ff && rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= PULSE_W'(RST_MIN_PULSE);
         max_ff    <= PULSE_W'(RST_MAX_PULSE);
         weight_ff <= WEIGHT_W'(RST_WEIGHT);
         inv_ff    <= 1'b0;
         def_ff    <= PULSE_W'(RST_DEFAULT);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_PULSE: min_ff    <= csr_wr_data[PULSE_W-1:0];
            CSR_MAX_PULSE: max_ff    <= csr_wr_data[PULSE_W-1:0];
            CSR_WEIGHT:    weight_ff <= csr_wr_data[WEIGHT_W-1:0];
            CSR_INVERTED:  inv_ff    <= csr_wr_data[0];
            CSR_DEFAULT:   def_ff    <= csr_wr_data[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // range, clamp and mirror helpers
   always_comb begin
      span_neg = (max_ff < min_ff);
      span_mag = span_neg ? (min_ff - max_ff) : (max_ff - min_ff);
      bnd_lo   = span_neg ? max_ff : min_ff;
      bnd_hi   = span_neg ? min_ff : max_ff;
      priority if (def_ff < bnd_lo) begin
         dflt_clamp = bnd_lo;
      end else if (def_ff > bnd_hi) begin
         dflt_clamp = bnd_hi;
      end else begin
         dflt_clamp = def_ff;
      end
      dflt_off   = span_neg ? (min_ff - dflt_clamp) : (dflt_clamp - min_ff);
      dflt_pulse = inv_ff ? (max_ff + min_ff - dflt_clamp) : dflt_clamp;
      pos_eff    = inv_ff ? (PM_W - req_ff.position) : req_ff.position;
      pos_oor    = (req_ff.position > PM_W);
      cur_ge     = (current_ff >= target_ff);
      tick_mag   = cur_ge ? (current_ff - target_ff) : (target_ff - current_ff);
   end

   // shared adder: multiply adds the multiplicand, divide subtracts the divisor
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_MUL: begin
            alu_a = {1'b0, hi_ff};
            alu_b = {1'b0, opd_ff};
         end
         ST_DIV: begin
            alu_a   = {hi_ff, lo_ff[15]};
            alu_b   = {1'b0, opd_ff};
            alu_sub = 1'b1;
         end
         default: ;
      endcase
      alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {17'd0, alu_sub};
      mul_sum = lo_ff[0] ? alu_res[16:0] : {1'b0, hi_ff};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if ((req_ff.req_type == REQ_MOVE && !pos_oor) ||
                req_ff.req_type == REQ_TICK || req_ff.req_type == REQ_INIT) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) state_in = (req_ff.req_type == REQ_TICK) ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_comb begin
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      opd_in = opd_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      oor_in = oor_ff;
      arg_in = arg_ff;
      unique case (state_ff)
         ST_LOAD: begin
            hi_in  = '0;
            cnt_in = STEP_LAST;
            oor_in = (req_ff.req_type == REQ_MOVE) && pos_oor;
            unique case (req_ff.req_type)
               REQ_MOVE: begin
                  lo_in  = pos_eff;
                  opd_in = span_mag;
                  neg_in = span_neg;
                  arg_in = pos_eff;
               end
               REQ_TICK: begin
                  lo_in  = tick_mag;
                  opd_in = weight_ff;
                  neg_in = !cur_ge;
               end
               REQ_INIT: begin
                  lo_in  = dflt_off;
                  opd_in = PM_W;
                  arg_in = dflt_pulse;
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            hi_in  = mul_sum[16:1];
            lo_in  = {mul_sum[0], lo_ff[15:1]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               // product is complete: load the divisor
               cnt_in = STEP_LAST;
               opd_in = (req_ff.req_type == REQ_MOVE) ? PM_W : span_mag;
            end
         end
         ST_DIV: begin
            hi_in  = alu_res[17] ? alu_res[15:0] : alu_a[15:0];
            lo_in  = {lo_ff[14:0], alu_res[17]};
            cnt_in = cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) req_ff <= req_word;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      opd_ff <= opd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      oor_ff <= oor_in;
      arg_ff <= arg_in;
   end

   // finish: apply quotient or product to the pulse state
   always_comb begin
      move_pulse  = neg_ff ? (min_ff - lo_ff) : (min_ff + lo_ff);
      init_pos    = (span_mag == '0) ? '0 : lo_ff;
      init_stored = inv_ff ? (PM_W - init_pos) : init_pos;
      tick_base   = {2'b00, target_ff, 16'h8000};
      tick_prod   = {2'b00, hi_ff, lo_ff};
      tick_sum    = neg_ff ? (tick_base - tick_prod) : (tick_base + tick_prod);
      tick_pulse  = tick_sum[31:16];

      target_in  = target_ff;
      current_in = current_ff;
      stored_in  = stored_ff;
      unique case (req_ff.req_type)
         REQ_MOVE: begin
            if (!oor_ff) begin
               target_in = move_pulse;
               stored_in = arg_ff;
            end
         end
         REQ_TICK: current_in = tick_pulse;
         REQ_INIT: begin
            target_in  = arg_ff;
            current_in = arg_ff;
            stored_in  = init_stored;
         end
         default: ;
      endcase
      logical_in = inv_ff ? (PM_W - stored_in) : stored_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= PULSE_W'(RST_DEFAULT);
         current_ff <= PULSE_W'(RST_DEFAULT);
         stored_ff  <= POS_W'(RST_STORED);
      end else if (fin_go) begin
         target_ff  <= target_in;
         current_ff <= current_in;
         stored_ff  <= stored_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_ff.target_pulse_us  <= target_in;
         rsp_ff.current_pulse_us <= current_in;
         rsp_ff.logical_position <= logical_in;
         rsp_ff.status           <= oor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `SPS_ASSERT_NEXT(a_take_to_load, clock, reset, req_take, state_ff == ST_LOAD, "word taken but sequencer did not start")
   `SPS_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FIN), "result raised without finish step")
   `SPS_ASSERT_NEXT(a_mul_to_div, clock, reset, state_ff == ST_MUL && cnt_ff == '0 && req_ff.req_type != REQ_TICK, state_ff == ST_DIV && cnt_ff == STEP_LAST, "divide did not follow multiply")

endmodule

[tb/servo_pulse_checker.sv]
// Scoreboard for the servo pulse mapper: watches request, response and register ports,
// keeps its own model of the pulse state and compares every response word.
// Depends on sps_pkg only.
module servo_pulse_checker #(
   parameter int unsigned POSITION_MAX = 999
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  sps_pkg::sps_req_type           req_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  sps_pkg::sps_rsp_type           rsp_word,
   input  logic                           csr_wr_en,
   input  logic [sps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sps_pkg::CSR_DATA_W-1:0] csr_wr_data,
   output int                             fail_count,
   output int                             outstanding
);
   import sps_pkg::*;

   localparam int MAX_REPORTS = 10;

   // register copies
   logic [15:0] min_us, max_us, weight, def_us;
   logic        inv;

   // pulse state copies
   logic [15:0] tgt_us, cur_us, stored_pos;

   sps_rsp_type pulse_expect_q[$];
   int          words_checked;

   // linear map, quotient truncated toward zero, span may be negative
   function automatic logic [15:0] position_to_pulse(input logic [15:0] p);
      longint lo, span, pmax;
      lo   = longint'(min_us);
      span = longint'(max_us) - lo;
      pmax = longint'(POSITION_MAX);
      return 16'(lo + (longint'(p) * span) / pmax);
   endfunction

   // inverse map used by init, clamped to 0..POSITION_MAX
   function automatic logic [15:0] pulse_to_position(input logic [15:0] us);
      longint lo, span, pmax, q;
      lo   = longint'(min_us);
      span = longint'(max_us) - lo;
      pmax = longint'(POSITION_MAX);
      if (span == 0) return 16'd0;
      q = ((longint'(us) - lo) * pmax) / span;
      if (q < 0) q = 0;
      if (q > pmax) q = pmax;
      return 16'(q);
   endfunction

   // exponential filter step, round half up
   function automatic void smooth_current();
      logic [63:0] s;
      s = 64'(tgt_us) * (64'd65536 - 64'(weight)) + 64'(cur_us) * 64'(weight);
      cur_us = 16'((s + 64'd32768) >> 16);
   endfunction

   // init: clamp default into the span, mirror if inverted
   function automatic void load_default_pulse();
      logic [15:0] lo, hi, d, p;
      lo = (min_us < max_us) ? min_us : max_us;
      hi = (min_us < max_us) ? max_us : min_us;
      d  = def_us;
      if (d < lo) d = lo;
      if (d > hi) d = hi;
      p = pulse_to_position(d);
      if (inv) begin
         d = max_us + min_us - d;
         p = 16'(POSITION_MAX - p);
      end
      tgt_us     = d;
      cur_us     = d;
      stored_pos = p;
   endfunction

   // apply one request word and return the response it must produce
   function automatic sps_rsp_type servo_next_word(input sps_req_type w);
      sps_rsp_type r;
      logic [15:0] pos;
      r.status = 1'b0;
      case (w.req_type)
         REQ_MOVE: begin
            if (32'(w.position) > POSITION_MAX) begin
               r.status = 1'b1;
            end else begin
               pos = inv ? 16'(POSITION_MAX - w.position) : w.position;
               tgt_us     = position_to_pulse(pos);
               stored_pos = pos;
            end
         end
         REQ_TICK: smooth_current();
         REQ_INIT: load_default_pulse();
         default: ;
      endcase
      r.target_pulse_us  = tgt_us;
      r.current_pulse_us = cur_us;
      r.logical_position = inv ? 16'(POSITION_MAX - stored_pos) : stored_pos;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      sps_rsp_type exp_w;
      if (reset) begin
         min_us = 16'(RST_MIN_PULSE);
         max_us = 16'(RST_MAX_PULSE);
         weight = 16'(RST_WEIGHT);
         def_us = 16'(RST_DEFAULT);
         inv    = 1'b0;
         load_default_pulse();
         smooth_current();
         pulse_expect_q.delete();
         fail_count    = 0;
         outstanding   = 0;
         words_checked = 0;
      end else begin
         // response side first: it can never belong to this cycle's request
         if (rsp_valid && !rsp_stall) begin
            if (pulse_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: response word with nothing pending: %p", $time, rsp_word);
            end else begin
               exp_w = pulse_expect_q.pop_front();
               words_checked++;
               if (rsp_word.target_pulse_us  !== exp_w.target_pulse_us  ||
                   rsp_word.current_pulse_us !== exp_w.current_pulse_us ||
                   rsp_word.logical_position !== exp_w.logical_position ||
                   rsp_word.status           !== exp_w.status) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: word %0d: expected tgt %0d cur %0d pos %0d st %0d",
                              $time, words_checked, exp_w.target_pulse_us,
                              exp_w.current_pulse_us, exp_w.logical_position,
                              exp_w.status, "; got tgt %0d cur %0d pos %0d st %0d",
                              rsp_word.target_pulse_us, rsp_word.current_pulse_us,
                              rsp_word.logical_position, rsp_word.status);
               end
            end
         end
         if (req_valid && !req_stall)
            pulse_expect_q.push_back(servo_next_word(req_word));
         // register writes are to be made only while idle; the checker does not enforce it
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_PULSE: min_us = csr_wr_data;
               CSR_MAX_PULSE: max_us = csr_wr_data;
               CSR_WEIGHT:    weight = csr_wr_data;
               CSR_INVERTED:  inv    = csr_wr_data[0];
               CSR_DEFAULT:   def_us = csr_wr_data;
               default: ;
            endcase
         end
         outstanding = pulse_expect_q.size();
      end
   end

endmodule

[tb/tb_servo_pulse_mapper_smoother.sv]
// Top of the servo pulse mapper testbench: clock, reset, stimulus and verdict.
// Depends on sps_pkg, servo_pulse_mapper_smoother and servo_pulse_checker.
module tb_servo_pulse_mapper_smoother;
   import sps_pkg::*;

   localparam int unsigned POS_MAX = 999;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int NUM_PHASES      = 6;
   localparam int WORDS_PER_PHASE = 250;
   localparam int HOLD_CYCLES     = 400;
   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_CYCLES    = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   sps_req_type           req_word;
   logic                  rsp_valid;
   logic                  rsp_stall;
   sps_rsp_type           rsp_word;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   int   fail_count;
   int   outstanding;
   logic idle_on;
   int   hold_asked;
   int   quiet_cycles = 0;
   int   n_moves = 0, n_out_range = 0, n_ticks = 0, n_inits = 0, n_unused = 0;

   servo_pulse_mapper_smoother #(
      .POSITION_MAX(POS_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   servo_pulse_checker #(
      .POSITION_MAX(POS_MAX)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .fail_count (fail_count),
      .outstanding(outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: random stall, plus a long hold-off on request
   initial begin : rsp_drive
      int hold_left;
      int hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_done != hold_asked) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 21);
         end
      end
   end

   // offer one request word, with random gaps ahead of it
   task automatic send_word(input logic [REQ_TYPE_W-1:0] kind, input logic [15:0] pos);
      while (idle_on && $urandom_range(99) < 21) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_word.req_type <= kind;
      req_word.position <= pos;
      do @(posedge clock); while (req_stall);
      case (kind)
         REQ_MOVE: begin
            n_moves++;
            if (32'(pos) > POS_MAX) n_out_range++;
         end
         REQ_TICK: n_ticks++;
         REQ_INIT: n_inits++;
         default:  n_unused++;
      endcase
   endtask

   // mostly in-range moves and ticks, some out-of-range moves, inits and unused codes
   task automatic send_random_word();
      int roll;
      int pick;
      roll = $urandom_range(99);
      pick = $urandom_range(9);
      if (roll < 40) begin
         if (pick == 0)      send_word(REQ_MOVE, 16'd0);
         else if (pick == 1) send_word(REQ_MOVE, 16'(POS_MAX));
         else                send_word(REQ_MOVE, 16'($urandom_range(POS_MAX)));
      end else if (roll < 48) begin
         if (pick < 5) send_word(REQ_MOVE, 16'($urandom_range(65535, POS_MAX + 1)));
         else          send_word(REQ_MOVE, 16'($urandom));
      end else if (roll < 85) begin
         send_word(REQ_TICK, 16'($urandom));
      end else if (roll < 96) begin
         send_word(REQ_INIT, 16'($urandom));
      end else begin
         send_word(REQ_UNUSED, 16'($urandom));
      end
   endtask

   // stop offering and wait for every pending response
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
   endtask

   task automatic write_servo_regs(input logic [15:0] lo_us, input logic [15:0] hi_us,
                                   input logic [15:0] wt, input logic inv_mode,
                                   input logic [15:0] dflt_us);
      write_reg(CSR_MIN_PULSE, lo_us);
      write_reg(CSR_MAX_PULSE, hi_us);
      write_reg(CSR_WEIGHT, wt);
      write_reg(CSR_INVERTED, {15'd0, inv_mode});
      write_reg(CSR_DEFAULT, dflt_us);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      int phase;
      int k;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      idle_on     = 1'b1;
      hold_asked  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset state, position extremes, out of range, every request code
      send_word(REQ_TICK, 16'd0);
      send_word(REQ_MOVE, 16'd0);
      send_word(REQ_MOVE, 16'(POS_MAX));
      send_word(REQ_MOVE, 16'(POS_MAX + 1));
      send_word(REQ_MOVE, 16'hFFFF);
      send_word(REQ_MOVE, 16'h5555);
      send_word(REQ_MOVE, 16'hAAAA);
      send_word(REQ_MOVE, 16'd500);
      send_word(REQ_TICK, 16'hFFFF);
      send_word(REQ_TICK, 16'd0);
      send_word(REQ_INIT, 16'd0);
      send_word(REQ_UNUSED, 16'hFFFF);
      send_word(REQ_MOVE, 16'd1);
      send_word(REQ_MOVE, 16'(POS_MAX - 1));
      send_word(REQ_TICK, 16'd0);
      send_word(REQ_INIT, 16'hFFFF);
      send_word(REQ_TICK, 16'd0);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: write_servo_regs(16'd0, 16'd65535, 16'd0, 1'b0, 16'd65535);
            1: write_servo_regs(16'd65535, 16'd0, 16'd65535, 1'b1, 16'd0);
            2: write_servo_regs(16'd2000, 16'd1000, 16'd32768, 1'b0, 16'd3000);
            3: write_servo_regs(16'd1234, 16'd1234, 16'd1, 1'b1, 16'd77);
            default: write_servo_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                      1'($urandom_range(1)), 16'($urandom));
         endcase
         // one phase runs with no idling on either side
         idle_on <= (phase != 3);
         send_word(REQ_INIT, 16'd0);
         send_word(REQ_MOVE, 16'd0);
         send_word(REQ_MOVE, 16'(POS_MAX));
         send_word(REQ_TICK, 16'd0);
         for (k = 0; k < WORDS_PER_PHASE; k++) begin
            if (phase == 1 && k == 40) hold_asked <= hold_asked + 1;
            if (phase == 2 && k == 120) drain_results();
            send_random_word();
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d moves (%0d out of range), %0d ticks, %0d inits, %0d unused codes",
               n_moves, n_out_range, n_ticks, n_inits, n_unused);
      $display("over %0d register settings, with a receiver hold-off and a drained pause",
               NUM_PHASES + 1);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
